// ===== hdl/bmfns_pkg.sv =====
// ============================================================================
// bmfns_pkg
// Shared types, widths, request codes and helpers for the bitmap block.
// ============================================================================
`default_nettype none

package bmfns_pkg;

    // Word size of the bit store (fixed)
    localparam int WORD_BITS        = 64;
    localparam int BIT_SEL_W        = 6;
    localparam int DEFAULT_CAPACITY = 4096;

    // Port field widths
    localparam int REQ_W  = 3;
    localparam int IDX_W  = 13;
    localparam int CAP_W  = 13;
    localparam int FIDX_W = 12;

    // Width that holds any capacity up to the largest store
    localparam int CAP_CMP_W = 17;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [REQ_W-1:0]     req_t;

    // Request codes
    localparam req_t REQ_CLEAR_ALL = 3'd0;
    localparam req_t REQ_SET       = 3'd1;
    localparam req_t REQ_CLEAR     = 3'd2;
    localparam req_t REQ_READ      = 3'd3;
    localparam req_t REQ_FIND      = 3'd4;

    // Position of the lowest set bit of a nonzero word: isolate it, then encode
    function automatic logic [BIT_SEL_W-1:0] lowest_bit(input word_t w);
        word_t                 iso;
        logic [BIT_SEL_W-1:0]  pos;
        iso = w & (~w + word_t'(1));
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (iso[i]) begin
                pos = pos | BIT_SEL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bitmap_find_next_set.sv =====
// ============================================================================
// bitmap_find_next_set
// Bit store held as 64-bit words in one synchronous RAM, with set, clear,
// read, clear-all and find-next-set requests.
// ============================================================================
//
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+-----------------------------------
//  request  | in        | s_valid/s_ready  | s_req_type, s_index
//  result   | out       | m_valid/m_ready  | m_bit_value, m_found,
//           |           |                  | m_found_index, m_range_error
//  config   | in        | cfg_wr_en        | cfg_wr_data (capacity in use)
//
//  Set, clear, read: RAM read, then modify/write, then result (held until the
//  output register is free). Find: one word per cycle through the RAM read
//  port, from the word of s_index up to the last word within the capacity.
//  Clear all: one RAM word written per cycle, over all NWORDS words.
//  After reset the same clearing pass runs over all NWORDS words with s_ready low.
//  One transaction is in work at a time; a finished result waits in the output
//  register while the next transaction is accepted.
//
`default_nettype none

module bitmap_find_next_set #(
    parameter int CAPACITY = bmfns_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [bmfns_pkg::CAP_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [bmfns_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [bmfns_pkg::IDX_W-1:0]   s_index,
    // result channel
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_bit_value,
    output      logic                          m_found,
    output      logic [bmfns_pkg::FIDX_W-1:0]  m_found_index,
    output      logic                          m_range_error
);
    import bmfns_pkg::*;

    localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [WA_W-1:0]      LAST_ADDR = WA_W'(NWORDS - 1);
    localparam logic [CAP_CMP_W-1:0] CAP_LIM   = CAP_CMP_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [WA_W-1:0]    ptr_reg, ptr_next;
    logic               clr_resp_reg, clr_resp_next;
    req_t               req_reg, req_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    word_t              mask_reg, mask_next;

    logic               res_bit_reg, res_bit_next;
    logic               res_found_reg, res_found_next;
    logic [FIDX_W-1:0]  res_fidx_reg, res_fidx_next;
    logic               res_err_reg, res_err_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_bit_reg, m_bit_next;
    logic               m_found_reg, m_found_next;
    logic [FIDX_W-1:0]  m_fidx_reg, m_fidx_next;
    logic               m_err_reg, m_err_next;

    // Word RAM
    word_t              mem [NWORDS];
    word_t              rdata_reg;
    logic [WA_W-1:0]    rd_addr;
    logic               mem_we;
    logic [WA_W-1:0]    mem_wa;
    word_t              mem_wd;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [CAP_CMP_W-1:0] cap_ext;
    logic [CAP_CMP_W-1:0] eff_cap;
    logic [CAP_CMP_W-1:0] cap_m1;
    logic [31:0]          last_word32;
    logic [31:0]          ptr32;
    logic [31:0]          pos32;
    logic [31:0]          s_word32;
    logic [WA_W-1:0]      s_word;
    logic                 in_range;
    logic                 at_last;
    logic                 out_free;
    logic                 accept;
    word_t                bit_mask;
    word_t                cur;

    assign cap_ext     = CAP_CMP_W'(cap_reg);
    assign eff_cap     = (cap_ext < CAP_LIM) ? cap_ext : CAP_LIM;
    assign cap_m1      = eff_cap - CAP_CMP_W'(1);
    assign last_word32 = 32'(cap_m1) >> BIT_SEL_W;
    assign ptr32       = 32'(ptr_reg);
    assign at_last     = (ptr32 >= last_word32);
    assign in_range    = (CAP_CMP_W'(idx_reg) < eff_cap);
    assign s_word32    = 32'(s_index) >> BIT_SEL_W;
    assign s_word      = s_word32[WA_W-1:0];
    assign bit_mask    = word_t'(1) << idx_reg[BIT_SEL_W-1:0];
    assign cur         = rdata_reg & mask_reg;
    assign pos32       = (ptr32 << BIT_SEL_W) | 32'(lowest_bit(cur));

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Control and datapath next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        ptr_next       = ptr_reg;
        clr_resp_next  = clr_resp_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        res_bit_next   = res_bit_reg;
        res_found_next = res_found_reg;
        res_fidx_next  = res_fidx_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg;
        m_bit_next     = m_bit_reg;
        m_found_next   = m_found_reg;
        m_fidx_next    = m_fidx_reg;
        m_err_next     = m_err_reg;
        mem_we         = 1'b0;
        mem_wa         = ptr_reg;
        mem_wd         = '0;

        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // write one zero word per cycle
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                ptr_next = ptr_reg + WA_W'(1);
                if (ptr_reg == LAST_ADDR) begin
                    ptr_next   = '0;
                    state_next = clr_resp_reg ? ST_HOLD : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    req_next       = s_req_type;
                    idx_next       = s_index;
                    mask_next      = '1 << s_index[BIT_SEL_W-1:0];
                    res_bit_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_fidx_next  = '0;
                    res_err_next   = 1'b0;
                    if (s_req_type == REQ_CLEAR_ALL) begin
                        ptr_next      = '0;
                        clr_resp_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        ptr_next   = s_word;
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                // RAM data for word ptr_reg is in rdata_reg
                state_next = ST_HOLD;
                case (req_reg) inside
                    REQ_SET, REQ_CLEAR, REQ_READ: begin
                        if (!in_range) begin
                            res_err_next = 1'b1;
                        end else if (req_reg == REQ_SET) begin
                            mem_we = 1'b1;
                            mem_wd = rdata_reg | bit_mask;
                        end else if (req_reg == REQ_CLEAR) begin
                            mem_we = 1'b1;
                            mem_wd = rdata_reg & ~bit_mask;
                        end else begin
                            res_bit_next = |(rdata_reg & bit_mask);
                        end
                    end
                    REQ_FIND: begin
                        if (in_range) begin
                            if (cur != '0) begin
                                if (pos32 < 32'(eff_cap)) begin
                                    res_found_next = 1'b1;
                                    res_fidx_next  = pos32[FIDX_W-1:0];
                                end
                            end else if (!at_last) begin
                                // next word, full mask
                                ptr_next   = ptr_reg + WA_W'(1);
                                mask_next  = '1;
                                state_next = ST_EXEC;
                            end
                        end
                    end
                    default: begin
                        // unknown request: all-zero result
                    end
                endcase
            end

            ST_HOLD: begin
                // move the result into the output register once it is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_bit_next    = res_bit_reg;
                    m_found_next  = res_found_reg;
                    m_fidx_next   = res_fidx_reg;
                    m_err_next    = res_err_reg;
                    clr_resp_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM read address: next word to present in rdata_reg
    assign rd_addr = (state_reg == ST_IDLE) ? s_word : ptr_next;

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cap_reg      <= CAP_RESET;
            ptr_reg      <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            ptr_reg      <= ptr_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        mask_reg      <= mask_next;
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        res_fidx_reg  <= res_fidx_next;
        res_err_reg   <= res_err_next;
        m_bit_reg     <= m_bit_next;
        m_found_reg   <= m_found_next;
        m_fidx_reg    <= m_fidx_next;
        m_err_reg     <= m_err_next;
    end

    // ------------------------------------------------------------------
    // Word RAM, one write and one registered read per cycle.
    // Writes happen in CLEAR and EXEC; both are followed by a HOLD or IDLE
    // state, so a written word is read back for use no sooner
    // than the accept of a later transaction and no forwarding path is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
    end

    assign m_valid       = m_valid_reg;
    assign m_bit_value   = m_bit_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_fidx_reg;
    assign m_range_error = m_err_reg;

endmodule

`default_nettype wire

// ===== hdl/bmfns_checker.sv =====
// ============================================================================
// bmfns_checker
// Port-level checks for bitmap_find_next_set, bound to the top level.
// ============================================================================
`default_nettype none

module bmfns_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_bit_value,
    input wire logic                          m_found,
    input wire logic [bmfns_pkg::FIDX_W-1:0]  m_found_index,
    input wire logic                          m_range_error
);

    // reset starts the clearing pass, so no request is taken right after
    a_reset_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high in the cycle after reset");

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // a result is either a search hit or a range error, never both
    a_found_vs_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_range_error))
        else $error("found and range_error both set");

    // a search hit never carries a read bit value
    a_found_vs_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_bit_value))
        else $error("found and bit_value both set");

    // stalled result stays valid and keeps its found index
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_index))
        else $error("stalled result changed");

endmodule

bind bitmap_find_next_set bmfns_checker u_bmfns_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_bit_value   (m_bit_value),
    .m_found       (m_found),
    .m_found_index (m_found_index),
    .m_range_error (m_range_error)
);

`default_nettype wire

// ===== bench/tb_bitmap_find_next_set.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_bitmap_find_next_set
// Self-checking bench for the bitmap store. A shadow copy of the bit words
// predicts every result. Directed requests cover the field extremes and the
// capacity corner cases. Random traffic then runs under several capacity
// settings, with random idling on both channels and one long result stall.
// ============================================================================

module tb_bitmap_find_next_set;
    import bmfns_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int STORE_BITS       = DEFAULT_CAPACITY;
    localparam int STORE_WORDS      = STORE_BITS / WORD_BITS;
    localparam int LIMIT_CYCLES     = 600000;
    localparam int LONG_HOLD_CYCLES = 300;
    // longer than a full clear or a full-store search
    localparam int SETTLE_CYCLES    = STORE_WORDS + 16;
    localparam int MAX_PRINTED      = 40;

    // request codes the block treats as no-ops
    localparam req_t REQ_UNUSED_5 = 3'd5;
    localparam req_t REQ_UNUSED_6 = 3'd6;
    localparam req_t REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic              bit_value;
        logic              found;
        logic [FIDX_W-1:0] found_index;
        logic              range_error;
    } bmp_result_t;

    typedef struct {
        bmp_result_t res;
        int          seq;
    } pending_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type    = REQ_CLEAR_ALL;
    logic [IDX_W-1:0]  s_index       = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_bit_value;
    logic              m_found;
    logic [FIDX_W-1:0] m_found_index;
    logic              m_range_error;

    // shadow of the block's state and configuration
    word_t             shadow_words [STORE_WORDS];
    logic [CAP_W-1:0]  cap_setting = CAP_RESET;

    pending_t          pending_results [$];
    int                requests_accepted = 0;
    int                error_count       = 0;
    int                tx_idle_pct       = 0;
    int                rx_idle_pct       = 0;
    bit                hold_off_request  = 1'b0;

    bitmap_find_next_set #(
        .CAPACITY(STORE_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bit_value  (m_bit_value),
        .m_found      (m_found),
        .m_found_index(m_found_index),
        .m_range_error(m_range_error)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int effective_capacity();
        return (int'(cap_setting) > STORE_BITS) ? STORE_BITS : int'(cap_setting);
    endfunction

    function automatic int first_one(word_t w);
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                return i;
            end
        end
        return WORD_BITS - 1;
    endfunction

    // applies one request to the shadow store and returns its result
    function automatic bmp_result_t predict_bitmap_result(req_t kind,
                                                          logic [IDX_W-1:0] idx);
        bmp_result_t r;
        int          cap;
        int          w;
        int          last;
        int          pos;
        word_t       mask;
        word_t       cur;
        r   = '0;
        cap = effective_capacity();
        case (kind)
            REQ_CLEAR_ALL: begin
                foreach (shadow_words[i]) begin
                    shadow_words[i] = '0;
                end
            end
            REQ_SET, REQ_CLEAR, REQ_READ: begin
                if (int'(idx) >= cap) begin
                    r.range_error = 1'b1;
                end else begin
                    w    = int'(idx[IDX_W-1:BIT_SEL_W]);
                    mask = word_t'(1) << idx[BIT_SEL_W-1:0];
                    if (kind == REQ_SET) begin
                        shadow_words[w] = shadow_words[w] | mask;
                    end else if (kind == REQ_CLEAR) begin
                        shadow_words[w] = shadow_words[w] & ~mask;
                    end else begin
                        r.bit_value = |(shadow_words[w] & mask);
                    end
                end
            end
            REQ_FIND: begin
                if (int'(idx) < cap) begin
                    w    = int'(idx[IDX_W-1:BIT_SEL_W]);
                    cur  = shadow_words[w] & ((~word_t'(0)) << idx[BIT_SEL_W-1:0]);
                    last = (cap - 1) / WORD_BITS;
                    // scan forward word by word, never past the last valid word
                    while (cur == '0 && w < last) begin
                        w++;
                        cur = shadow_words[w];
                    end
                    if (cur != '0) begin
                        pos = w * WORD_BITS + first_one(cur);
                        // hits beyond the capacity in use are not reported
                        if (pos < cap) begin
                            r.found       = 1'b1;
                            r.found_index = FIDX_W'(pos);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // one request transaction; the result is predicted at acceptance
    task automatic send_request(req_t kind, logic [IDX_W-1:0] idx);
        int       gap;
        pending_t entry;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_index    <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        entry.res = predict_bitmap_result(kind, idx);
        entry.seq = requests_accepted;
        pending_results.push_back(entry);
        requests_accepted++;
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_setting = value;
        @(posedge aclk);
    endtask

    // mostly in range, some near word edges and the capacity, some anywhere
    function automatic logic [IDX_W-1:0] rand_index();
        int cap;
        int sel;
        int w;
        int off;
        cap = effective_capacity();
        sel = $urandom_range(0, 99);
        if (sel < 10 || cap == 0) begin
            return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        end
        if (sel < 20) begin
            w   = $urandom_range(0, (cap - 1) / WORD_BITS + 1);
            off = $urandom_range(0, 1) ? (WORD_BITS - 1 - $urandom_range(0, 1))
                                       : $urandom_range(0, 1);
            return IDX_W'(w * WORD_BITS + off);
        end
        if (sel < 30) begin
            return IDX_W'(cap - 2 + $urandom_range(0, 3));
        end
        return IDX_W'($urandom_range(0, cap - 1));
    endfunction

    task automatic send_random_request();
        int   sel;
        req_t kind;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            kind = REQ_SET;
        end else if (sel < 45) begin
            kind = REQ_CLEAR;
        end else if (sel < 60) begin
            kind = REQ_READ;
        end else if (sel < 96) begin
            kind = REQ_FIND;
        end else if (sel < 98) begin
            kind = REQ_CLEAR_ALL;
        end else begin
            kind = req_t'($urandom_range(REQ_UNUSED_5, REQ_UNUSED_7));
        end
        send_request(kind, rand_index());
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                n = pick_gap(rx_idle_pct);
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want, int seq);
        if (got != want) begin
            report_mismatch($sformatf("transaction %0d %s: got %0d, expected %0d",
                                      seq, name, got, want));
        end
    endtask

    always @(posedge aclk) begin : result_checker
        pending_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no request pending");
            end else begin
                want = pending_results.pop_front();
                check_field("bit_value", m_bit_value, want.res.bit_value, want.seq);
                check_field("found", m_found, want.res.found, want.seq);
                check_field("found_index", m_found_index, want.res.found_index,
                            want.seq);
                check_field("range_error", m_range_error, want.res.range_error,
                            want.seq);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // field extremes, every request code, word edges, unknown codes
    task automatic test_directed();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        write_capacity(CAP_RESET);
        send_request(REQ_READ, 13'd0);
        send_request(REQ_FIND, 13'd0);
        send_request(REQ_SET, 13'd0);
        send_request(REQ_SET, 13'd63);
        send_request(REQ_SET, 13'd64);
        send_request(REQ_SET, 13'd4095);
        send_request(REQ_SET, 13'd4096);
        send_request(REQ_SET, 13'd8191);
        send_request(REQ_READ, 13'd4095);
        send_request(REQ_FIND, 13'd1);
        send_request(REQ_FIND, 13'd65);
        send_request(REQ_FIND, 13'd4096);
        send_request(REQ_CLEAR, 13'd63);
        send_request(REQ_FIND, 13'd1);
        send_request(REQ_UNUSED_5, 13'h1555);
        send_request(REQ_UNUSED_6, 13'h0AAA);
        send_request(REQ_UNUSED_7, 13'd8191);
        send_request(REQ_CLEAR_ALL, 13'd8191);
        send_request(REQ_FIND, 13'd0);
        drain_results();
    endtask

    // lowered capacity hides stored bits, zero and oversized capacities
    task automatic test_capacity_edges();
        send_request(REQ_SET, 13'd4000);
        drain_results();
        write_capacity(13'd100);
        send_request(REQ_FIND, 13'd11);
        send_request(REQ_SET, 13'd99);
        send_request(REQ_FIND, 13'd11);
        send_request(REQ_READ, 13'd4000);
        drain_results();
        write_capacity(13'd0);
        send_request(REQ_FIND, 13'd0);
        send_request(REQ_SET, 13'd0);
        drain_results();
        write_capacity(13'd8191);
        send_request(REQ_SET, 13'd4096);
        send_request(REQ_FIND, 13'd100);
        drain_results();
        write_capacity(13'd1);
        send_request(REQ_FIND, 13'd0);
        send_request(REQ_SET, 13'd1);
        drain_results();
    endtask

    // results held off for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        write_capacity(CAP_RESET);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_request = 1'b1;
        repeat (24) send_random_request();
        drain_results();
    endtask

    task automatic run_random_phase(int cap, int count, int tx_pct, int rx_pct);
        write_capacity(CAP_W'(cap));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_random_request();
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(STORE_BITS, 250, 30, 30);
        run_random_phase(100, 80, 0, 0);
        run_random_phase(65, 60, 60, 10);
        run_random_phase(64, 60, 10, 60);
        run_random_phase(0, 30, 30, 30);
        run_random_phase((1 << CAP_W) - 1, 100, 30, 30);
        run_random_phase(1, 40, 30, 30);
        run_random_phase($urandom_range(1, STORE_BITS), 100, 40, 40);
        run_random_phase($urandom_range(0, (1 << CAP_W) - 1), 60, 20, 20);
        run_random_phase(STORE_BITS, 100, 0, 50);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (shadow_words[i]) begin
            shadow_words[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity_edges();
        test_result_backpressure();
        test_random_traffic();
        drain_results();
        if (error_count == 0) begin
            $display("[bitmap_find_next_set] OK");
        end else begin
            $display("[bitmap_find_next_set] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("[bitmap_find_next_set] ERROR");
        $finish;
    end

endmodule

// ===== bitmap_find_next_set.f =====
hdl/bmfns_pkg.sv
hdl/bitmap_find_next_set.sv
hdl/bmfns_checker.sv
bench/tb_bitmap_find_next_set.sv
